### hw/rtl/ect_pkg.sv
// Entity component table package: sizes, request and status codes, sequencer states.
// Used by entity_component_table; no dependencies.
package ect_pkg;

  localparam int MAX_ENTITIES   = 64;
  localparam int NUM_TYPES      = 4;
  localparam int SLOTS_PER_TYPE = 64;
  localparam int PAYLOAD_BITS   = 64;

  localparam int ENT_W   = $clog2(MAX_ENTITIES);
  localparam int CNT_W   = $clog2(MAX_ENTITIES + 1);
  localparam int TYPE_W  = $clog2(NUM_TYPES);
  localparam int SLOT_W  = $clog2(SLOTS_PER_TYPE);
  localparam int FILL_W  = $clog2(SLOTS_PER_TYPE + 1);
  localparam int SADDR_W = TYPE_W + SLOT_W;
  localparam int TOTAL_SLOTS = NUM_TYPES * SLOTS_PER_TYPE;

  typedef enum logic [2:0] {
    OP_CREATE = 3'd0,
    OP_DELETE = 3'd1,
    OP_ADD    = 3'd2,
    OP_REMOVE = 3'd3,
    OP_READ   = 3'd4,
    OP_WRITE  = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NO_FREE = 3'd1,
    ST_UNUSED  = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_DISPATCH,
    S_SCAN,
    S_DEL,
    S_FIND,
    S_MOVE,
    S_DONE
  } state_t;

endpackage

### hw/rtl/entity_component_table.sv
// Entity component table: entity pool, per-type packed slot stores, swap remove.
// Depends on ect_pkg.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | req_type, entity_id, comp_type, write_value
//  out     | output    | out_valid/out_stall| status, new_entity, read_value, comp_mask
//
// One word at a time. A request passes through S_LOAD, S_DISPATCH, its search and S_DONE,
// and the next word is taken once the block is back in S_IDLE. Create scans the in-use bits
// one entity a cycle. Remove/read/write walk the type's slots one a cycle through the slot
// RAM read port, and remove adds a move step in S_MOVE. Delete visits each type in S_DEL
// and walks the slots and moves the last slot for each component that the entity holds.
// Sync reset clears the in-use bits, counts and fills; slot RAMs are not cleared.
// in_stall is high from accept until the result is loaded into the output register.
module entity_component_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic [5:0]  entity_id,
  input  logic [1:0]  comp_type,
  input  logic [63:0] write_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [5:0]  new_entity,
  output logic [63:0] read_value,
  output logic [3:0]  comp_mask
);

  localparam int NT  = ect_pkg::NUM_TYPES;
  localparam int EW  = ect_pkg::ENT_W;
  localparam int TW  = ect_pkg::TYPE_W;
  localparam int SW  = ect_pkg::SLOT_W;
  localparam int FW  = ect_pkg::FILL_W;
  localparam int CW  = ect_pkg::CNT_W;
  localparam int AW  = ect_pkg::SADDR_W;
  localparam int DW  = ect_pkg::PAYLOAD_BITS;
  localparam int ME  = ect_pkg::MAX_ENTITIES;

  ect_pkg::state_t state, state_next;

  logic [2:0]    req;
  logic [EW-1:0] e;
  logic [TW-1:0] t;
  logic [DW-1:0] wv;

  logic [NT-1:0] cmask, cmask_next;
  logic [TW-1:0] ty, ty_next;
  logic [FW-1:0] idx, idx_next;
  logic          chk, chk_next;
  logic [SW-1:0] pos, pos_next;
  logic [EW-1:0] scan, scan_next;

  logic [ME-1:0] in_use, in_use_next;
  logic [CW-1:0] live_cnt, live_cnt_next;
  logic [FW-1:0] fill [NT];
  logic [FW-1:0] fill_next [NT];

  ect_pkg::status_t res_status, res_status_next;
  logic [EW-1:0]    res_new, res_new_next;
  logic [DW-1:0]    res_rv, res_rv_next;
  logic [NT-1:0]    res_mask, res_mask_next;

  logic             out_valid_next;
  ect_pkg::status_t out_status, out_status_next;
  logic [EW-1:0]    out_new, out_new_next;
  logic [DW-1:0]    out_rv, out_rv_next;
  logic [NT-1:0]    out_mask, out_mask_next;

  // component bit memory
  logic [NT-1:0] comp_mem [ME];
  logic [NT-1:0] cmask_rd;
  logic          comp_we;
  logic [EW-1:0] comp_waddr;
  logic [NT-1:0] comp_wdata;

  // slot memories
  logic [EW-1:0] owner_mem [ect_pkg::TOTAL_SLOTS];
  logic [DW-1:0] pay_mem [ect_pkg::TOTAL_SLOTS];
  logic [EW-1:0] owner_q;
  logic [DW-1:0] pay_q;
  logic [AW-1:0] slot_raddr, slot_waddr;
  logic          owner_we, pay_we;
  logic [EW-1:0] owner_wdata;
  logic [DW-1:0] pay_wdata;

  logic          accept;
  logic          hit;
  logic [FW-1:0] fill_t;
  logic [NT-1:0] bit_ty;
  logic [NT-1:0] bit_t;
  logic [NT-1:0] dropped;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ect_pkg::S_IDLE);
  assign fill_t   = fill[ty];
  assign bit_ty   = NT'(1) << ty;
  assign bit_t    = NT'(1) << t;
  assign dropped  = cmask & ~bit_ty;
  assign hit      = chk && (owner_q == e);

  always_ff @(posedge clk) begin
    if (comp_we) begin
      comp_mem[comp_waddr] <= comp_wdata;
    end
    cmask_rd <= comp_mem[e];
  end

  always_ff @(posedge clk) begin
    if (owner_we) begin
      owner_mem[slot_waddr] <= owner_wdata;
    end
    if (pay_we) begin
      pay_mem[slot_waddr] <= pay_wdata;
    end
    owner_q <= owner_mem[slot_raddr];
    pay_q   <= pay_mem[slot_raddr];
  end

  always_comb begin
    state_next      = state;
    cmask_next      = cmask;
    ty_next         = ty;
    idx_next        = idx;
    chk_next        = 1'b0;
    pos_next        = pos;
    scan_next       = scan;
    in_use_next     = in_use;
    live_cnt_next   = live_cnt;
    fill_next       = fill;
    res_status_next = res_status;
    res_new_next    = res_new;
    res_rv_next     = res_rv;
    res_mask_next   = res_mask;
    out_valid_next  = out_valid && out_stall;
    out_status_next = out_status;
    out_new_next    = out_new;
    out_rv_next     = out_rv;
    out_mask_next   = out_mask;
    comp_we         = 1'b0;
    comp_waddr      = e;
    comp_wdata      = '0;
    slot_raddr      = {ty, idx[SW-1:0]};
    slot_waddr      = {ty, pos};
    owner_we        = 1'b0;
    pay_we          = 1'b0;
    owner_wdata     = e;
    pay_wdata       = '0;

    case (state)
      ect_pkg::S_IDLE: begin
        if (accept) begin
          res_new_next = '0;
          res_rv_next  = '0;
          state_next   = ect_pkg::S_LOAD;
        end
      end

      ect_pkg::S_LOAD: begin
        state_next = ect_pkg::S_DISPATCH;
      end

      ect_pkg::S_DISPATCH: begin
        cmask_next      = cmask_rd;
        res_status_next = ect_pkg::ST_OK;
        res_mask_next   = in_use[e] ? cmask_rd : '0;
        state_next      = ect_pkg::S_DONE;
        if (req == ect_pkg::OP_CREATE) begin
          res_mask_next = '0;
          if (live_cnt >= CW'(ME)) begin
            res_status_next = ect_pkg::ST_NO_FREE;
          end else begin
            scan_next  = '0;
            state_next = ect_pkg::S_SCAN;
          end
        end else if (req inside {ect_pkg::OP_DELETE, ect_pkg::OP_ADD, ect_pkg::OP_REMOVE,
                                 ect_pkg::OP_READ, ect_pkg::OP_WRITE}) begin
          if (!in_use[e]) begin
            res_status_next = ect_pkg::ST_UNUSED;
            res_mask_next   = '0;
          end else if (req == ect_pkg::OP_DELETE) begin
            ty_next    = '0;
            state_next = ect_pkg::S_DEL;
          end else if (req == ect_pkg::OP_ADD) begin
            if ((cmask_rd & bit_t) == '0) begin
              if (fill[t] >= FW'(ect_pkg::SLOTS_PER_TYPE)) begin
                res_status_next = ect_pkg::ST_FULL;
              end else begin
                slot_waddr    = {t, fill[t][SW-1:0]};
                owner_we      = 1'b1;
                pay_we        = 1'b1;
                fill_next[t]  = fill[t] + 1'b1;
                comp_we       = 1'b1;
                comp_wdata    = cmask_rd | bit_t;
                res_mask_next = cmask_rd | bit_t;
              end
            end
          end else if ((cmask_rd & bit_t) == '0) begin
            res_status_next = ect_pkg::ST_ABSENT;
          end else begin
            ty_next    = t;
            idx_next   = '0;
            state_next = ect_pkg::S_FIND;
          end
        end
      end

      ect_pkg::S_SCAN: begin
        if (!in_use[scan]) begin
          in_use_next[scan] = 1'b1;
          live_cnt_next     = live_cnt + 1'b1;
          comp_we           = 1'b1;
          comp_waddr        = scan;
          res_new_next      = scan;
          res_status_next   = ect_pkg::ST_OK;
          state_next        = ect_pkg::S_DONE;
        end else begin
          scan_next = scan + 1'b1;
        end
      end

      ect_pkg::S_DEL: begin
        if ((cmask & bit_ty) != '0) begin
          idx_next   = '0;
          state_next = ect_pkg::S_FIND;
        end else if (ty == TW'(NT - 1)) begin
          in_use_next[e]  = 1'b0;
          live_cnt_next   = live_cnt - 1'b1;
          res_status_next = ect_pkg::ST_OK;
          res_mask_next   = '0;
          state_next      = ect_pkg::S_DONE;
        end else begin
          ty_next = ty + 1'b1;
        end
      end

      ect_pkg::S_FIND: begin
        // owner_q holds slot idx-1 when chk is set
        if (hit) begin
          pos_next = SW'(idx - 1'b1);
          if (req == ect_pkg::OP_READ) begin
            res_rv_next     = pay_q;
            res_status_next = ect_pkg::ST_OK;
            res_mask_next   = cmask;
            state_next      = ect_pkg::S_DONE;
          end else if (req == ect_pkg::OP_WRITE) begin
            slot_waddr      = {ty, SW'(idx - 1'b1)};
            pay_we          = 1'b1;
            pay_wdata       = wv;
            res_status_next = ect_pkg::ST_OK;
            res_mask_next   = cmask;
            state_next      = ect_pkg::S_DONE;
          end else begin
            slot_raddr = {ty, SW'(fill_t - 1'b1)};
            state_next = ect_pkg::S_MOVE;
          end
        end else if (idx < fill_t) begin
          chk_next = 1'b1;
          idx_next = idx + 1'b1;
        end else if (req == ect_pkg::OP_READ || req == ect_pkg::OP_WRITE) begin
          res_status_next = ect_pkg::ST_ABSENT;
          res_mask_next   = cmask;
          state_next      = ect_pkg::S_DONE;
        end else begin
          // not found: only the bit goes
          cmask_next = dropped;
          if (req == ect_pkg::OP_DELETE) begin
            state_next = ect_pkg::S_DEL;
          end else begin
            comp_we         = 1'b1;
            comp_wdata      = dropped;
            res_status_next = ect_pkg::ST_OK;
            res_mask_next   = dropped;
            state_next      = ect_pkg::S_DONE;
          end
        end
      end

      ect_pkg::S_MOVE: begin
        // last slot of the type fills the gap
        owner_we      = 1'b1;
        pay_we        = 1'b1;
        owner_wdata   = owner_q;
        pay_wdata     = pay_q;
        fill_next[ty] = fill_t - 1'b1;
        cmask_next    = dropped;
        if (req == ect_pkg::OP_DELETE) begin
          state_next = ect_pkg::S_DEL;
        end else begin
          comp_we         = 1'b1;
          comp_wdata      = dropped;
          res_status_next = ect_pkg::ST_OK;
          res_mask_next   = dropped;
          state_next      = ect_pkg::S_DONE;
        end
      end

      ect_pkg::S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_valid_next  = 1'b1;
          out_status_next = res_status;
          out_new_next    = res_new;
          out_rv_next     = res_rv;
          out_mask_next   = res_mask;
          state_next      = ect_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = ect_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ect_pkg::S_IDLE;
      in_use    <= '0;
      live_cnt  <= '0;
      out_valid <= 1'b0;
      chk       <= 1'b0;
      for (int i = 0; i < NT; i++) begin
        fill[i] <= '0;
      end
    end else begin
      state     <= state_next;
      in_use    <= in_use_next;
      live_cnt  <= live_cnt_next;
      out_valid <= out_valid_next;
      chk       <= chk_next;
      fill      <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req <= req_type;
      e   <= entity_id;
      t   <= comp_type;
      wv  <= write_value[DW-1:0];
    end
    cmask      <= cmask_next;
    ty         <= ty_next;
    idx        <= idx_next;
    pos        <= pos_next;
    scan       <= scan_next;
    res_status <= res_status_next;
    res_new    <= res_new_next;
    res_rv     <= res_rv_next;
    res_mask   <= res_mask_next;
    out_status <= out_status_next;
    out_new    <= out_new_next;
    out_rv     <= out_rv_next;
    out_mask   <= out_mask_next;
  end

  assign status     = out_status;
  assign new_entity = out_new;
  assign read_value = out_rv;
  assign comp_mask  = out_mask;

  a_live_count: assert property (@(posedge clk) disable iff (rst)
    live_cnt == CW'($countones(in_use)))
    else $error("live count out of step with in-use bits");

  a_search_bound: assert property (@(posedge clk) disable iff (rst)
    state == ect_pkg::S_FIND |-> idx <= fill_t)
    else $error("slot search ran past type fill");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall && !$stable(state))
    else $error("accepted word did not start the sequencer");

  a_move_follows_hit: assert property (@(posedge clk) disable iff (rst)
    state == ect_pkg::S_MOVE |-> $past(hit) && fill_t != '0)
    else $error("swap move without a found slot");

endmodule
